// ===== rtl/bmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmdc_pkg
// Shared constants and payload types of the block-mean DC offset remover.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdc_pkg;

  // Default configuration of the block
  localparam int unsigned MAX_BLOCK_DEF      = 64;
  localparam int unsigned MEAN_FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int          SMP_MAX  = 32767;
  localparam int          SMP_MIN  = -32768;

  // Divider defaults: sum of MAX_BLOCK samples over a count up to MAX_BLOCK
  localparam int unsigned CNT_W_DEF = $clog2(MAX_BLOCK_DEF + 1);
  localparam int unsigned SUM_W_DEF = SAMPLE_W + CNT_W_DEF;

  // Register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd9830;

  typedef enum logic {
    REG_CHANNEL_MODE  = 1'b0,
    REG_SMOOTH_WEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       last_in_block;
  } bmdc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_out;
    logic                       overflow_flag;
  } bmdc_out_t;

endpackage

`default_nettype wire

// ===== rtl/bmdc_if.sv =====
// ----------------------------------------------------------------------------
// bmdc_if
// Valid/ready channels carrying input samples and DC-free results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmdc_in_if;
  logic               valid;
  logic               ready;
  bmdc_pkg::bmdc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmdc_out_if;
  logic                valid;
  logic                ready;
  bmdc_pkg::bmdc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmdc_div.sv =====
// ----------------------------------------------------------------------------
// bmdc_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bmdc_div #(
  parameter int unsigned NUM_W = bmdc_pkg::SUM_W_DEF,
  parameter int unsigned DEN_W = bmdc_pkg::CNT_W_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_sub;
  logic           take;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    take    = (rem_sh >= {1'b0, den_q});
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: work on magnitudes, restore the sign at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
      quo_q <= num_i[NUM_W-1] ? (-num_i) : num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], take};
      rem_q <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ===== rtl/block_mean_dc_offset_remover.sv =====
// ----------------------------------------------------------------------------
// block_mean_dc_offset_remover
// Buffers a block of mono or stereo samples, updates a smoothed per-channel
// mean from the block average and replays the block with the mean removed.
// ----------------------------------------------------------------------------
// Input is ready throughout the collection of a block. When the item marked
// last arrives, the block average of each active channel comes from a shared
// bit-serial divider, started in S_DIV and awaited in S_WAIT; S_MUL registers
// the weighted difference and S_UPD updates the smoothed mean. A stereo block
// runs these states for the left and then the right channel, a mono block for
// the left only. The block is then replayed from the sample store; the store
// read is registered ahead of the output register, and a new word is read
// only after the previous one has been loaded there. Input is held off from
// the last input transfer of a block until its final result is in the output
// register, and the hold-off grows while the output stalls. Register writes
// are expected only while the block is idle.
`default_nettype none

module block_mean_dc_offset_remover #(
  parameter int unsigned MAX_BLOCK      = bmdc_pkg::MAX_BLOCK_DEF,
  parameter int unsigned MEAN_FRAC_BITS = bmdc_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bmdc_in_if.sink                       in_i,
  bmdc_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmdc_pkg::APB_AW-1:0]   paddr,
  input  logic [bmdc_pkg::APB_DW-1:0]   pwdata,
  output logic [bmdc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  import bmdc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned MEAN_W = SAMPLE_W + MEAN_FRAC_BITS;
  localparam int unsigned DIFF_W = MEAN_W + 1;
  localparam int unsigned PROD_W = DIFF_W + WEIGHT_W + 1;
  localparam int unsigned DC_W   = MEAN_W + 1;
  localparam int unsigned WORD_W = 2 * SAMPLE_W;

  localparam logic [DC_W-1:0]        FRAC_MASK =
      DC_W'((64'd1 << MEAN_FRAC_BITS) - 64'd1);
  localparam logic signed [DC_W-1:0] SAT_HI = DC_W'(SMP_MAX);
  localparam logic signed [DC_W-1:0] SAT_LO = DC_W'(SMP_MIN);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_DIV,
    S_WAIT,
    S_MUL,
    S_UPD,
    S_REPLAY
  } state_e;

  // Subtract the mean, truncate the fraction toward zero, saturate
  function automatic logic signed [SAMPLE_W-1:0] remove_dc(
    input logic signed [SAMPLE_W-1:0] s,
    input logic signed [MEAN_W-1:0]   m
  );
    logic signed [DC_W-1:0] d;
    logic signed [DC_W-1:0] q;
    d = ($signed(DC_W'(s)) <<< MEAN_FRAC_BITS) - $signed(DC_W'(m));
    q = d >>> MEAN_FRAC_BITS;
    if (d[DC_W-1] && ((d & FRAC_MASK) != '0)) begin
      q = q + DC_W'(1);
    end
    if (q > SAT_HI) begin
      remove_dc = SAT_HI[SAMPLE_W-1:0];
    end else if (q < SAT_LO) begin
      remove_dc = SAT_LO[SAMPLE_W-1:0];
    end else begin
      remove_dc = q[SAMPLE_W-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic                mode_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                cfg_wr;
  cfg_reg_e            cfg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CHANNEL_MODE:  mode_q   <= pwdata[0];
        REG_SMOOTH_WEIGHT: weight_q <= pwdata[WEIGHT_W-1:0];
        default:           mode_q   <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CHANNEL_MODE:  prdata = {{(APB_DW-1){1'b0}}, mode_q};
      REG_SMOOTH_WEIGHT: prdata = {{(APB_DW-WEIGHT_W){1'b0}}, weight_q};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and datapath state
  // --------------------------------------------------------------------------
  state_e                   state_q;
  logic signed [SUM_W-1:0]  sum_l_q;
  logic signed [SUM_W-1:0]  sum_r_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic                     drop_q;
  logic                     stereo_q;
  logic                     chan_q;
  logic signed [SAMPLE_W-1:0] avg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MEAN_W-1:0] mean_l_q;
  logic signed [MEAN_W-1:0] mean_r_q;
  logic        [CNT_W-1:0]  rep_q;
  logic                     rd_pend_q;
  logic                     rd_last_q;
  logic        [WORD_W-1:0] rd_data_q;
  logic                     out_valid_q;
  bmdc_out_t                out_data_q;

  logic in_fire;
  logic has_room;
  logic wr_en;
  logic rd_issue;

  assign in_i.ready = (state_q == S_COLLECT);
  assign in_fire    = in_i.valid && in_i.ready;
  assign has_room   = (cnt_q < CNT_W'(MAX_BLOCK));
  assign wr_en      = in_fire && has_room;
  assign rd_issue   = (state_q == S_REPLAY) && !rd_pend_q
                   && (!out_valid_q || out_o.ready) && (rep_q != cnt_q);

  // Shared divider for the block averages
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_num;
  logic signed [SUM_W-1:0] div_quo;

  assign div_start = (state_q == S_DIV);
  assign div_num   = chan_q ? sum_r_q : sum_l_q;

  bmdc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Mean update: mean += floor(w * (avg - mean) / 2^16)
  logic signed [MEAN_W-1:0] cur_mean;
  logic signed [MEAN_W-1:0] avg_fix;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [MEAN_W-1:0] new_mean;

  always_comb begin
    cur_mean = chan_q ? mean_r_q : mean_l_q;
    avg_fix  = $signed(MEAN_W'(avg_q)) <<< MEAN_FRAC_BITS;
    diff     = $signed(DIFF_W'(avg_fix)) - $signed(DIFF_W'(cur_mean));
    prod     = diff * $signed({1'b0, weight_q});
    new_mean = cur_mean + MEAN_W'(prod_q >>> WEIGHT_W);
  end

  // Result for the word just read from the store
  bmdc_out_t out_next;

  always_comb begin
    out_next.out_left      = remove_dc(rd_data_q[SAMPLE_W-1:0], mean_l_q);
    out_next.out_right     = stereo_q ? remove_dc(rd_data_q[WORD_W-1:SAMPLE_W], mean_r_q)
                                      : '0;
    out_next.last_out      = rd_last_q;
    out_next.overflow_flag = drop_q;
  end

  // Sample store: one write port, one registered read port
  logic [WORD_W-1:0] store_mem [MAX_BLOCK];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[cnt_q[ADDR_W-1:0]] <= {in_i.data.sample_right, in_i.data.sample_left};
    end
    if (rd_issue) begin
      rd_data_q <= store_mem[rep_q[ADDR_W-1:0]];
    end
  end

  // Block-end arithmetic registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && div_done) begin
      avg_q <= div_quo[SAMPLE_W-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= prod;
    end
  end

  // Sequencer, accumulators, means and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      stereo_q    <= 1'b0;
      chan_q      <= 1'b0;
      mean_l_q    <= '0;
      mean_r_q    <= '0;
      rep_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Drain the output register; a new load below takes precedence
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_COLLECT: begin
          if (in_fire) begin
            if (has_room) begin
              sum_l_q <= sum_l_q + SUM_W'(in_i.data.sample_left);
              sum_r_q <= sum_r_q + SUM_W'(in_i.data.sample_right);
              cnt_q   <= cnt_q + CNT_W'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.data.last_in_block) begin
              stereo_q <= mode_q;
              chan_q   <= 1'b0;
              state_q  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (chan_q) begin
            mean_r_q <= new_mean;
          end else begin
            mean_l_q <= new_mean;
          end
          if (!chan_q && stereo_q) begin
            chan_q  <= 1'b1;
            state_q <= S_DIV;
          end else begin
            chan_q  <= 1'b0;
            sum_l_q <= '0;
            sum_r_q <= '0;
            rep_q   <= '0;
            state_q <= S_REPLAY;
          end
        end
        S_REPLAY: begin
          rd_pend_q <= rd_issue;
          if (rd_issue) begin
            rd_last_q <= ((rep_q + CNT_W'(1)) == cnt_q);
            rep_q     <= rep_q + CNT_W'(1);
          end
          // Load the word read last cycle
          if (rd_pend_q) begin
            out_data_q  <= out_next;
            out_valid_q <= 1'b1;
            if (rd_last_q) begin
              cnt_q   <= '0;
              drop_q  <= 1'b0;
              state_q <= S_COLLECT;
            end
          end
        end
        default: begin
          state_q <= S_COLLECT;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BLOCK))
    else $error("item count beyond block capacity");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("store read returns while output register is occupied");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT))
    else $error("divider finished outside of its wait state");

  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLAY && rd_pend_q && rd_last_q)
      |=> (state_q == S_COLLECT && cnt_q == '0 && out_valid_q))
    else $error("block did not close after its final result");

endmodule

`default_nettype wire

// ===== sim/block_mean_dc_offset_remover_tb.sv =====
// ----------------------------------------------------------------------------
// block_mean_dc_offset_remover_tb
// Self-checking bench for the block-mean DC offset remover. Sample blocks are
// streamed in over the valid/ready input channel. Each accepted transfer feeds
// a behavioral model of the block buffer, the smoothed channel means and the
// DC-free replay. Replayed results are checked field by field against that
// model. Both channel sides stall at random, and channel mode and smoothing
// weight change between phases over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module block_mean_dc_offset_remover_tb;

  import bmdc_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 12;
  localparam longint      MEAN_SCALE     = longint'(1) << MEAN_FRAC_BITS_DEF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  bmdc_in_if  in_bus ();
  bmdc_out_if out_bus ();

  block_mean_dc_offset_remover dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores
  bmdc_in_t  samples_to_send[$];
  bmdc_out_t dc_free_expected[$];

  // Model state: block buffer, running sums and smoothed means
  logic [31:0]  block_words [MAX_BLOCK_DEF];
  longint       left_acc, right_acc;
  int unsigned  fill;
  longint       left_mean_q, right_mean_q;
  bit           block_dropped;

  // Register shadows, updated on each APB write transfer
  bit                  stereo_mode;
  logic [WEIGHT_W-1:0] weight_q16;

  // Run bookkeeping
  int  send_gap_pct, recv_stall_pct;
  bit  in_took;
  int  mismatches, items_taken, results_checked, blocks_closed, overflow_blocks;
  int  quiet_cycles;

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    in_took       = 1'b0;
    left_acc = 0; right_acc = 0; fill = 0;
    left_mean_q = 0; right_mean_q = 0; block_dropped = 1'b0;
    stereo_mode = 1'b0; weight_q16 = WEIGHT_RESET;
    mismatches = 0; items_taken = 0; results_checked = 0;
    blocks_closed = 0; overflow_blocks = 0; quiet_cycles = 0;
    send_gap_pct = 7; recv_stall_pct = 45;
  end

  // Move the smoothed mean toward the truncated block average
  function automatic longint smoothed(longint mean, longint sum, int unsigned n);
    longint avg, diff, w;
    avg  = sum / longint'(n);
    diff = avg * MEAN_SCALE - mean;
    w    = weight_q16;
    return mean + ((diff * w) >>> 16);
  endfunction

  // Subtract the mean, drop the fraction toward zero, saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] strip(logic [SAMPLE_W-1:0] raw,
                                                       longint mean);
    longint s, r;
    s = $signed(raw);
    r = (s * MEAN_SCALE - mean) / MEAN_SCALE;
    if (r > SMP_MAX) r = SMP_MAX;
    if (r < SMP_MIN) r = SMP_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  // Buffer one accepted sample pair; on the block end queue the replay
  task automatic take_sample(bmdc_in_t it);
    bmdc_out_t res;
    longint    l_s, r_s;
    l_s = $signed(it.sample_left);
    r_s = $signed(it.sample_right);
    if (fill < MAX_BLOCK_DEF) begin
      block_words[fill] = {it.sample_right, it.sample_left};
      left_acc  += l_s;
      right_acc += r_s;
      fill++;
    end else begin
      block_dropped = 1'b1;
    end
    if (!it.last_in_block) return;
    blocks_closed++;
    if (block_dropped) overflow_blocks++;
    if (fill > 0) begin
      left_mean_q = smoothed(left_mean_q, left_acc, fill);
      if (stereo_mode) right_mean_q = smoothed(right_mean_q, right_acc, fill);
    end
    for (int unsigned k = 0; k < fill; k++) begin
      res.out_left      = strip(block_words[k][15:0], left_mean_q);
      res.out_right     = stereo_mode ? strip(block_words[k][31:16], right_mean_q) : '0;
      res.last_out      = (k + 1 == fill);
      res.overflow_flag = block_dropped;
      dc_free_expected.push_back(res);
    end
    left_acc = 0; right_acc = 0; fill = 0; block_dropped = 1'b0;
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: check finished results first, then feed the accepted input
  always @(posedge clk_i) begin
    bmdc_out_t exp_r;
    in_took <= in_bus.valid && in_bus.ready;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_checked++;
      if (dc_free_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_bus.data);
      end else begin
        exp_r = dc_free_expected.pop_front();
        check_field("out_left", exp_r.out_left, out_bus.data.out_left);
        check_field("out_right", exp_r.out_right, out_bus.data.out_right);
        check_field("last_out", exp_r.last_out, out_bus.data.last_out);
        check_field("overflow_flag", exp_r.overflow_flag, out_bus.data.overflow_flag);
      end
    end
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      items_taken++;
      take_sample(in_bus.data);
    end
  end

  // Track register writes into the model shadows
  always @(posedge clk_i) begin
    if (psel && penable && pwrite && pready) begin
      case (cfg_reg_e'(paddr[2]))
        REG_CHANNEL_MODE:  stereo_mode <= pwdata[0];
        REG_SMOOTH_WEIGHT: weight_q16  <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Driver: advance the input on a transfer or while idle, toss ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || in_took) begin
        if (samples_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_bus.data  <= samples_to_send.pop_front();
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [APB_AW-1:0] reg_addr(cfg_reg_e r);
    return {r, 2'b00};
  endfunction

  // APB write: setup phase, then access phase
  task automatic apb_write(cfg_reg_e r, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(r);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers, with junk in the unused upper data bits
  task automatic set_config(bit stereo, int unsigned weight);
    apb_write(REG_CHANNEL_MODE, ($urandom() & ~32'h1) | stereo);
    apb_write(REG_SMOOTH_WEIGHT, ($urandom() & 32'hFFFF_0000) | weight[15:0]);
  endtask

  task automatic push_item(int l, int r, bit last);
    bmdc_in_t it;
    it.sample_left   = l[SAMPLE_W-1:0];
    it.sample_right  = r[SAMPLE_W-1:0];
    it.last_in_block = last;
    samples_to_send.push_back(it);
  endtask

  // Hold until the block has drained and replayed everything
  task automatic wait_idle();
    do @(posedge clk_i);
    while (samples_to_send.size() > 0 || in_bus.valid || dc_free_expected.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int clamp16(int v);
    return (v > SMP_MAX) ? SMP_MAX : (v < SMP_MIN) ? SMP_MIN : v;
  endfunction

  // One block of random length and content; a few run past capacity
  task automatic push_block();
    int len, pick, off_l, off_r, spread;
    bit dc_style;
    pick = $urandom_range(99);
    if (pick < 75)      len = $urandom_range(12, 1);
    else if (pick < 95) len = $urandom_range(64, 13);
    else                len = $urandom_range(70, 65);
    dc_style = $urandom_range(2) != 0;
    off_l  = $signed(16'($urandom()));
    off_r  = $signed(16'($urandom()));
    spread = 1 << $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if (dc_style) begin
        push_item(clamp16(off_l + $urandom_range(2 * spread) - spread),
                  clamp16(off_r + $urandom_range(2 * spread) - spread), i == len - 1);
      end else begin
        push_item($signed(16'($urandom())), $signed(16'($urandom())), i == len - 1);
      end
    end
  endtask

  task automatic random_segment(int n_items);
    int target;
    target = items_taken + samples_to_send.size() + n_items;
    while (items_taken + samples_to_send.size() < target) push_block();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Mono block at reset settings with field extremes
    push_item(SMP_MAX, SMP_MIN, 1'b0);
    push_item(SMP_MIN, SMP_MAX, 1'b0);
    push_item(0, -1, 1'b0);
    push_item(-1, 0, 1'b1);
    wait_idle();

    // Stereo at nearly full weight over three blocks: each mean moves almost to its block average
    set_config(1'b1, 65535);
    push_item(SMP_MAX, SMP_MIN, 1'b0);
    push_item(SMP_MAX, SMP_MIN, 1'b0);
    push_item(SMP_MIN, SMP_MAX, 1'b1);
    push_item(SMP_MIN, SMP_MAX, 1'b1);
    push_item(SMP_MAX, SMP_MIN, 1'b1);
    wait_idle();

    // Block too long, the final dropped item carries the block end
    for (int i = 0; i < 66; i++)
      push_item($signed(16'($urandom())), $signed(16'($urandom())), i == 65);
    wait_idle();

    // Zero weight holds both means
    set_config(1'b1, 0);
    push_item(1000, -1000, 1'b0);
    push_item(-20000, 30000, 1'b1);
    wait_idle();

    // Mode change in the middle of a block: the mode at its end governs
    set_config(1'b1, 30000);
    push_item(12345, -4321, 1'b0);
    push_item(-777, 8888, 1'b0);
    wait_idle();
    apb_write(REG_CHANNEL_MODE, 32'h0);
    push_item(5, 6, 1'b1);
    wait_idle();

    // Random traffic, sender rarely idle and receiver often stalled
    set_config(1'b0, $urandom_range(65535));
    random_segment(30);
    wait_idle();
    set_config(1'b1, $urandom_range(65535));
    random_segment(30);
    wait_idle();

    // Sender often idle, receiver rarely stalled
    send_gap_pct = 45; recv_stall_pct = 7;
    set_config(1'b1, 1);
    random_segment(30);
    wait_idle();
    set_config(1'b0, 32768);
    random_segment(30);
    wait_idle();

    // No idling on either side
    send_gap_pct = 0; recv_stall_pct = 0;
    set_config(1'b1, WEIGHT_RESET);
    random_segment(30);
    wait_idle();
    set_config(1'b1, $urandom_range(65535));
    random_segment(30);
    wait_idle();

    $display("Run covered %0d input items in %0d blocks (%0d over capacity),",
             items_taken, blocks_closed, overflow_blocks);
    $display("with %0d replayed results checked and %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmdc_pkg.sv
rtl/bmdc_if.sv
rtl/bmdc_div.sv
rtl/block_mean_dc_offset_remover.sv
sim/block_mean_dc_offset_remover_tb.sv
